// ===== hdl/double_ended_queue_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the double-ended queue
// Clocked, reset-gated concurrent assertions used by the checker.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define DEQ_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Assertion on the local clk and rst_n.
`define DEQ_ASSERT(lbl, prop, msg) `DEQ_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// ===== hdl/deq_pkg.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue package
// Shared field widths, codes and the command word between front and back.
// ---------------------------------------------------------------------------
package deq_pkg;

  localparam int FUNC_W   = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 11;

  // Command queue between front and back end
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_SIZE       = 3'd4,
    FN_EMPTY      = 3'd5,
    FN_PEEK_FRONT = 3'd6,
    FN_PEEK_BACK  = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_SIZE,
    OP_EMPTY
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } bk_state_t;

  typedef struct packed {
    op_t                      op;
    logic                     is_back;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

endpackage

// ===== hdl/deq_channels.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue channels
// Valid/ready interfaces for the command and result words.
// ---------------------------------------------------------------------------
interface deq_in_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, func, push_value, input ready);
  modport sink   (input valid, func, push_value, output ready);
endinterface

interface deq_out_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] answer;
  logic [STATUS_W-1:0]      status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, answer, status, occupancy, input ready);
  modport sink   (input valid, answer, status, occupancy, output ready);
endinterface

// ===== hdl/deq_front.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue front end
// Decodes the function code into an operation and the end it works on.
// ---------------------------------------------------------------------------
module deq_front import deq_pkg::*; (
  deq_in_if.sink in_chan,
  output logic   cmd_valid,
  input  logic   cmd_ready,
  output cmd_t   cmd
);

  func_t func;

  assign func          = func_t'(in_chan.func);
  assign in_chan.ready = cmd_ready;
  assign cmd_valid     = in_chan.valid;

  always_comb begin
    cmd.value   = in_chan.push_value;
    cmd.is_back = (func == FN_PUSH_BACK) || (func == FN_POP_BACK) ||
                  (func == FN_PEEK_BACK);
    unique case (func) inside
      FN_PUSH_FRONT, FN_PUSH_BACK: cmd.op = OP_PUSH;
      FN_POP_FRONT, FN_POP_BACK:   cmd.op = OP_POP;
      FN_PEEK_FRONT, FN_PEEK_BACK: cmd.op = OP_PEEK;
      FN_SIZE:                     cmd.op = OP_SIZE;
      FN_EMPTY:                    cmd.op = OP_EMPTY;
      default:                     cmd.op = OP_SIZE;
    endcase
  end

endmodule

// ===== hdl/deq_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue command FIFO
// Short queue of decoded commands between front and back end.
// ---------------------------------------------------------------------------
module deq_cmd_fifo import deq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t                  entry_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign push_ready = (cnt_r != CMDQ_CNT_W'(CMDQ_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/deq_back.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue back end
// Ring store, head/count pointers and the registered result word.
// ---------------------------------------------------------------------------
module deq_back import deq_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  deq_out_if.source   out_chan
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

  logic [DATA_WIDTH-1:0] ring_mem [DEPTH];

  bk_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic signed [DATA_WIDTH-1:0] rd_word;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0] answer_r;
  status_t                  status_r;
  logic [OCC_W-1:0]         occ_r;

  logic                     slot_free, cmd_take, empty, full, read_hit;
  logic [SUM_W-1:0]         sum_push, sum_tail;
  logic [IDX_W-1:0]         idx_push, idx_tail, head_inc, head_dec;
  logic                     wr_en, rd_en;
  logic [IDX_W-1:0]         wr_idx, rd_idx;
  logic [DATA_WIDTH-1:0]    wr_data;
  logic                     res_load;
  logic signed [WORD_W-1:0] res_answer;
  status_t                  res_status;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign cmd_ready = (state_r == BK_IDLE) && slot_free;
  assign cmd_take  = cmd_valid && cmd_ready;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign read_hit  = ((cmd.op == OP_POP) || (cmd.op == OP_PEEK)) && !empty;
  assign rd_word   = rd_data_r;
  assign wr_data   = DATA_WIDTH'(cmd.value);

  // Ring index arithmetic, one compare-subtract for the wrap
  assign sum_push = SUM_W'(head_r) + SUM_W'(count_r);
  assign sum_tail = sum_push - SUM_W'(1);
  assign idx_push = (sum_push >= DEPTH_S) ? IDX_W'(sum_push - DEPTH_S) : IDX_W'(sum_push);
  assign idx_tail = (sum_tail >= DEPTH_S) ? IDX_W'(sum_tail - DEPTH_S) : IDX_W'(sum_tail);
  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (cmd_take && read_hit) state_nxt = BK_READ;
      BK_READ: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    wr_idx     = idx_push;
    rd_en      = 1'b0;
    rd_idx     = head_r;
    res_load   = 1'b0;
    res_answer = '0;
    res_status = ST_OK;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_take) begin
          case (cmd.op) inside
            OP_PUSH: begin
              if (full) begin
                res_load   = 1'b1;
                res_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
                if (!cmd.is_back) begin
                  wr_idx   = head_dec;
                  head_nxt = head_dec;
                end
              end
            end
            OP_POP, OP_PEEK: begin
              if (empty) begin
                res_load   = 1'b1;
                res_answer = '1;
                res_status = ST_EMPTY;
              end else begin
                rd_en  = 1'b1;
                rd_idx = cmd.is_back ? idx_tail : head_r;
                if (cmd.op == OP_POP) begin
                  count_nxt = count_r - 1'b1;
                  if (!cmd.is_back) head_nxt = head_inc;
                end
              end
            end
            OP_SIZE: begin
              res_load   = 1'b1;
              res_answer = WORD_W'(count_r);
            end
            OP_EMPTY: begin
              res_load   = 1'b1;
              res_answer = empty ? WORD_W'(1) : '0;
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        res_load   = 1'b1;
        res_answer = WORD_W'(rd_word);
      end
      default: ;
    endcase
  end

  always_comb begin
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      answer_r <= res_answer;
      status_r <= res_status;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ring_mem[rd_idx];
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.answer    = answer_r;
  assign out_chan.status    = status_r;
  assign out_chan.occupancy = occ_r;

endmodule

// ===== hdl/double_ended_queue.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue
// Ring-buffer deque of signed words with push/pop/peek at both ends.
// ---------------------------------------------------------------------------
// Commands enter on in_chan (func, push_value) and results leave on out_chan
// (answer, status, occupancy); a word moves when valid and ready are both
// high. An accepted push gives no result word, a push to a full queue gives
// one with status full, every other command gives exactly one. A push, size
// or empty test is handled in the back end's idle state; a pop or peek of a
// non-empty queue also passes through its read state, since the ring store's
// read data is registered before it reaches the result register. A two-word
// command queue sits between decode and execution, so in_chan keeps taking
// words until that queue is full while a result waits on out_chan. The store
// needs no clearing pass after reset: only entries that hold data are ever
// read. occupancy shows the entry count after the command, in 11 bits.
// ---------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  deq_in_if.sink     in_chan,
  deq_out_if.source  out_chan
);

  // decoded command from the front end into the queue
  logic fr_valid, fr_ready;
  cmd_t fr_cmd;

  // queued command into the back end
  logic bk_valid, bk_ready;
  cmd_t bk_cmd;

  deq_front u_front (
    .in_chan   (in_chan),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  deq_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_cmd   (fr_cmd),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_cmd    (bk_cmd)
  );

  // ring store, pointers and the result register
  deq_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (bk_valid),
    .cmd_ready (bk_ready),
    .cmd       (bk_cmd),
    .out_chan  (out_chan)
  );

endmodule

// ===== hdl/deq_checker.sv =====
// ---------------------------------------------------------------------------
// Double-ended queue checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "double_ended_queue_macros.svh"

module deq_checker import deq_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [WORD_W-1:0] answer,
  input logic [STATUS_W-1:0]      status,
  input logic [OCC_W-1:0]         occupancy
);

  `DEQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(answer) && $stable(status) && $stable(occupancy), "result word changed while stalled")
  `DEQ_ASSERT(a_empty_word, out_valid && (status == ST_EMPTY) |-> (answer == '1) && (occupancy == '0), "empty result not all ones or queue not empty")
  `DEQ_ASSERT(a_full_word, out_valid && (status == ST_FULL) |-> (answer == '0), "dropped push carries a nonzero answer")

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .answer    (out_chan.answer),
  .status    (out_chan.status),
  .occupancy (out_chan.occupancy)
);
